### sv/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg - homogeneous line clipper package
// Shared widths, coordinate and segment types, channel payload structs.
// ----------------------------------------------------------------------------
package hlc_pkg;

	localparam int CoordW    = 32;
	localparam int NumCoord  = 4;
	localparam int FracBits  = 16;
	localparam int NumPlanes = 6;
	localparam int IdxW      = 3;

	// boundary value and coordinate difference, exact
	localparam int EvalW  = CoordW + 1;
	// |eA|+|eB| never exceeds 2^33
	localparam int DenW   = CoordW + 2;
	localparam int RemW   = DenW + 1;
	// t in 0..1.0 inclusive
	localparam int QuotW  = FracBits + 1;
	localparam int PloW   = QuotW + FracBits;
	localparam int PhiW   = QuotW + 1 + EvalW - FracBits;
	localparam int SumW   = PhiW + 1;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef coord_t [NumCoord-1:0] vec_t;

	typedef struct packed {
		logic vis;
		vec_t pa;
		vec_t pb;
	} seg_st_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t a_w;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t b_w;
	} seg_item_t;

	typedef struct packed {
		logic   visible;
		coord_t out_a_x;
		coord_t out_a_y;
		coord_t out_a_z;
		coord_t out_a_w;
		coord_t out_b_x;
		coord_t out_b_y;
		coord_t out_b_z;
		coord_t out_b_w;
	} res_item_t;

	typedef struct packed {
		logic full;
		logic wr_valid;
	} buf_ctl_t;

endpackage

### sv/hlc_plane.sv
// ----------------------------------------------------------------------------
// hlc_plane - one clip plane
// Boundary values, 17-stage restoring divider for t, split multiply, and
// saturated move of the outside endpoint.
// ----------------------------------------------------------------------------
module hlc_plane #(
	parameter int Coord = 0,
	parameter bit Minus = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             up_valid,
	input  hlc_pkg::seg_st_t up_seg,
	output logic             dn_valid,
	output hlc_pkg::seg_st_t dn_seg
);

	localparam int CoordW = hlc_pkg::CoordW;
	localparam int NumC   = hlc_pkg::NumCoord;
	localparam int EvalW  = hlc_pkg::EvalW;
	localparam int DenW   = hlc_pkg::DenW;
	localparam int RemW   = hlc_pkg::RemW;
	localparam int QuotW  = hlc_pkg::QuotW;
	localparam int Frac   = hlc_pkg::FracBits;
	localparam int PloW   = hlc_pkg::PloW;
	localparam int PhiW   = hlc_pkg::PhiW;
	localparam int SumW   = hlc_pkg::SumW;
	localparam int WIdx   = NumC - 1;

	typedef logic signed [EvalW-1:0] eval_t;
	typedef eval_t [NumC-1:0] dvec_t;

	typedef struct packed {
		hlc_pkg::seg_st_t seg;
		logic             move;
		logic             mova;
		dvec_t            d;
	} carry_t;

	function automatic eval_t ext(hlc_pkg::coord_t c);
		return {c[CoordW-1], c};
	endfunction

	// s1: boundary values and differences
	logic             v_s1;
	hlc_pkg::seg_st_t seg_s1;
	eval_t            ea_s1, eb_s1;
	dvec_t            d_s1;
	eval_t            ea_c, eb_c;
	dvec_t            d_c;

	always_comb begin
		ea_c = Minus ? ext(up_seg.pa[WIdx]) - ext(up_seg.pa[Coord])
			: ext(up_seg.pa[WIdx]) + ext(up_seg.pa[Coord]);
		eb_c = Minus ? ext(up_seg.pb[WIdx]) - ext(up_seg.pb[Coord])
			: ext(up_seg.pb[WIdx]) + ext(up_seg.pb[Coord]);
		for (int i = 0; i < NumC; i++) begin
			d_c[i] = ext(up_seg.pb[i]) - ext(up_seg.pa[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= up_seg;
			ea_s1  <= ea_c;
			eb_s1  <= eb_c;
			d_s1   <= d_c;
		end
	end

	// s2: classify, numerator and denominator
	logic            v_s2;
	carry_t          car_s2;
	logic [DenW-1:0] num_s2, den_s2;
	logic            na, nb;
	logic [DenW-1:0] ea_w, eb_w;

	assign na   = ea_s1[EvalW-1];
	assign nb   = eb_s1[EvalW-1];
	assign ea_w = {ea_s1[EvalW-1], ea_s1};
	assign eb_w = {eb_s1[EvalW-1], eb_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s2.seg.pa  <= seg_s1.pa;
			car_s2.seg.pb  <= seg_s1.pb;
			car_s2.seg.vis <= seg_s1.vis & ~(na & nb);
			car_s2.move    <= seg_s1.vis & (na ^ nb);
			car_s2.mova    <= na;
			car_s2.d       <= d_s1;
			num_s2         <= na ? -ea_w : ea_w;
			// signs differ when used, so this is |eA|+|eB|
			den_s2         <= na ? eb_w - ea_w : ea_w - eb_w;
		end
	end

	// s3: one quotient bit per stage, msb first
	logic [QuotW-1:0] v_s3;
	carry_t           car_s3 [QuotW];
	logic [RemW-1:0]  rem_s3 [QuotW];
	logic [DenW-1:0]  den_s3 [QuotW];
	logic [QuotW-1:0] quo_s3 [QuotW];

	for (genvar k = 0; k < QuotW; k++) begin : g_div
		logic             v_in;
		carry_t           c_in;
		logic [RemW-1:0]  r_in, trial;
		logic [DenW-1:0]  dn_in;
		logic [QuotW-1:0] q_in;

		if (k == 0) begin : g_first
			assign v_in  = v_s2;
			assign c_in  = car_s2;
			assign r_in  = {1'b0, num_s2};
			assign dn_in = den_s2;
			assign q_in  = '0;
		end else begin : g_next
			assign v_in  = v_s3[k-1];
			assign c_in  = car_s3[k-1];
			assign r_in  = rem_s3[k-1];
			assign dn_in = den_s3[k-1];
			assign q_in  = quo_s3[k-1];
		end

		assign trial = (k == 0) ? r_in : {r_in[RemW-2:0], 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k] <= 1'b0;
			end else if (adv) begin
				v_s3[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				car_s3[k] <= c_in;
				den_s3[k] <= dn_in;
				if (trial >= {1'b0, dn_in}) begin
					rem_s3[k] <= trial - {1'b0, dn_in};
					quo_s3[k] <= {q_in[QuotW-2:0], 1'b1};
				end else begin
					rem_s3[k] <= trial;
					quo_s3[k] <= {q_in[QuotW-2:0], 1'b0};
				end
			end
		end
	end

	// s4: t times difference, split into low and high partial products
	logic                        v_s4;
	carry_t                      car_s4;
	logic [NumC-1:0][PloW-1:0]   plo_s4;
	logic signed [PhiW-1:0]      phi_s4 [NumC];
	logic [QuotW-1:0]            t_c;

	assign t_c = quo_s3[QuotW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3[QuotW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s4 <= car_s3[QuotW-1];
			for (int i = 0; i < NumC; i++) begin
				plo_s4[i] <= t_c * car_s3[QuotW-1].d[i][Frac-1:0];
				phi_s4[i] <= $signed({1'b0, t_c}) * $signed(car_s3[QuotW-1].d[i][EvalW-1:Frac]);
			end
		end
	end

	// s5: floor(t*d / 2^16)
	logic                   v_s5;
	carry_t                 car_s5;
	logic signed [PhiW-1:0] st_s5 [NumC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s5 <= car_s4;
			for (int i = 0; i < NumC; i++) begin
				st_s5[i] <= phi_s4[i] + $signed({1'b0, plo_s4[i][PloW-1:Frac]});
			end
		end
	end

	// s6: add to A, saturate, replace the outside endpoint
	logic             v_s6;
	hlc_pkg::seg_st_t seg_s6;
	hlc_pkg::vec_t    moved_c;
	logic signed [SumW-1:0] sum_c [NumC];

	always_comb begin
		for (int i = 0; i < NumC; i++) begin
			sum_c[i] = $signed({{(SumW-CoordW){car_s5.seg.pa[i][CoordW-1]}}, car_s5.seg.pa[i]})
				+ $signed({st_s5[i][PhiW-1], st_s5[i]});
			if (sum_c[i][SumW-1:CoordW-1] == '0 || sum_c[i][SumW-1:CoordW-1] == '1) begin
				moved_c[i] = sum_c[i][CoordW-1:0];
			end else if (sum_c[i][SumW-1]) begin
				moved_c[i] = {1'b1, {(CoordW-1){1'b0}}};
			end else begin
				moved_c[i] = {1'b0, {(CoordW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s6.vis <= car_s5.seg.vis;
			seg_s6.pa  <= (car_s5.move && car_s5.mova) ? moved_c : car_s5.seg.pa;
			seg_s6.pb  <= (car_s5.move && !car_s5.mova) ? moved_c : car_s5.seg.pb;
		end
	end

	assign dn_valid = v_s6;
	assign dn_seg   = seg_s6;

	// t never exceeds 1.0 and the remainder stays below the divisor
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3[QuotW-1] && car_s3[QuotW-1].move |-> quo_s3[QuotW-1] <= (1 << Frac))
		else $error("t above one");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3[QuotW-1] && car_s3[QuotW-1].move |->
		rem_s3[QuotW-1] < {1'b0, den_s3[QuotW-1]})
		else $error("divider remainder not below divisor");

endmodule

### sv/hlc_out_buf.sv
// ----------------------------------------------------------------------------
// hlc_out_buf - result register with skid entry
// Holds up to two results so the pipeline stalls only on a registered flag.
// ----------------------------------------------------------------------------
module hlc_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	input  hlc_pkg::res_item_t wr_data,
	output hlc_pkg::buf_ctl_t  ctl,
	output logic               res_valid,
	input  logic               res_ready,
	output hlc_pkg::res_item_t res
);

	logic               out_valid_q, skid_valid_q;
	hlc_pkg::res_item_t out_q, skid_q;
	logic               take;

	assign take = out_valid_q & res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (wr_valid) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (wr_valid) begin
			if (out_valid_q && !take) begin
				skid_q <= wr_data;
			end else begin
				out_q <= wr_data;
			end
		end
	end

	assign ctl.full     = skid_valid_q;
	assign ctl.wr_valid = wr_valid;
	assign res_valid    = out_valid_q;
	assign res          = out_q;

endmodule

### sv/homogeneous_line_clipper.sv
// ----------------------------------------------------------------------------
// homogeneous_line_clipper - clip-space line clipper, six planes
// Clips one segment per cycle, unless stalled, against w+x, w-x, w+y, w-y, w+z, w-z.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   seg     | seg_valid, seg_ready | endpoints A and B, signed Q16.16
//   res     | res_valid, res_ready | visible flag, clipped A and B
//
// one segment enters per cycle while seg_ready is high; each result passes
// 22 stages per plane (2 for boundary values, 17 for the t divider, 3 for
// the multiply, sum and saturate) and then the output register
// the 17 divider stages, one quotient bit each, set the depth
// reset clears only valid bits; no clearing pass
// a stall holds the whole pipeline; it starts only when the skid entry is full,
// so seg_ready comes straight from a flop
//
module homogeneous_line_clipper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_ready,
	input  hlc_pkg::seg_item_t seg,
	output logic               res_valid,
	input  logic               res_ready,
	output hlc_pkg::res_item_t res
);

	localparam int NumPlanes = hlc_pkg::NumPlanes;

	logic                   adv;
	logic [NumPlanes:0]     pv;
	hlc_pkg::seg_st_t       ps [NumPlanes+1];
	hlc_pkg::res_item_t     fin;
	hlc_pkg::buf_ctl_t      bctl;

	// whole pipeline moves unless the output skid entry is occupied
	assign adv       = ~bctl.full;
	assign seg_ready = adv;

	// pack the incoming transfer, x at index 0 and w at index 3
	assign pv[0]     = seg_valid;
	assign ps[0].vis = 1'b1;
	assign ps[0].pa  = {seg.a_w, seg.a_z, seg.a_y, seg.a_x};
	assign ps[0].pb  = {seg.b_w, seg.b_z, seg.b_y, seg.b_x};

	// planes in order: even index adds the coordinate, odd index subtracts it
	for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
		hlc_plane #(
			.Coord (p / 2),
			.Minus (p % 2 == 1)
		) u_plane (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.up_valid (pv[p]),
			.up_seg   (ps[p]),
			.dn_valid (pv[p+1]),
			.dn_seg   (ps[p+1])
		);
	end

	// rejected segments report all-zero endpoints
	always_comb begin
		fin.visible = ps[NumPlanes].vis;
		fin.out_a_x = ps[NumPlanes].vis ? ps[NumPlanes].pa[0] : '0;
		fin.out_a_y = ps[NumPlanes].vis ? ps[NumPlanes].pa[1] : '0;
		fin.out_a_z = ps[NumPlanes].vis ? ps[NumPlanes].pa[2] : '0;
		fin.out_a_w = ps[NumPlanes].vis ? ps[NumPlanes].pa[3] : '0;
		fin.out_b_x = ps[NumPlanes].vis ? ps[NumPlanes].pb[0] : '0;
		fin.out_b_y = ps[NumPlanes].vis ? ps[NumPlanes].pb[1] : '0;
		fin.out_b_z = ps[NumPlanes].vis ? ps[NumPlanes].pb[2] : '0;
		fin.out_b_w = ps[NumPlanes].vis ? ps[NumPlanes].pb[3] : '0;
	end

	// output register plus skid entry
	hlc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (pv[NumPlanes]),
		.wr_data   (fin),
		.ctl       (bctl),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// a stall needs a result waiting at the output
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_ready |-> res_valid)
		else $error("input stalled with no result pending");

	// a rejected segment carries zero endpoints
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.visible |->
		res.out_a_x == '0 && res.out_a_y == '0 && res.out_a_z == '0 &&
		res.out_a_w == '0 && res.out_b_x == '0 && res.out_b_y == '0 &&
		res.out_b_z == '0 && res.out_b_w == '0)
		else $error("rejected segment with nonzero endpoints");

endmodule
